// ----- rtl/core/bmpw_pkg.sv -----
package bmpw_pkg;

	// Datapath operations, one per microcode step
	localparam logic [2:0] OP_WAIT   = 3'd0;
	localparam logic [2:0] OP_STRIDE = 3'd1;
	localparam logic [2:0] OP_ISIZE  = 3'd2;
	localparam logic [2:0] OP_FSIZE  = 3'd3;
	localparam logic [2:0] OP_HDR    = 3'd4;
	localparam logic [2:0] OP_PIX    = 3'd5;
	localparam logic [2:0] OP_PAD    = 3'd6;
	localparam logic [2:0] OP_NOP    = 3'd7;

	// Header half-word sources
	localparam logic [3:0] F_ZERO   = 4'd0;
	localparam logic [3:0] F_FS_LO  = 4'd1;
	localparam logic [3:0] F_FS_HI  = 4'd2;
	localparam logic [3:0] F_OFF    = 4'd3;
	localparam logic [3:0] F_DIB    = 4'd4;
	localparam logic [3:0] F_W      = 4'd5;
	localparam logic [3:0] F_H      = 4'd6;
	localparam logic [3:0] F_BPP    = 4'd7;
	localparam logic [3:0] F_COMP   = 4'd8;
	localparam logic [3:0] F_ISZ_LO = 4'd9;
	localparam logic [3:0] F_ISZ_HI = 4'd10;

	// Configuration register indexes
	localparam logic [1:0] REG_HEADER_VERSION = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

	localparam int CfgDataW = 13;

	// Decoded control for the current step
	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  lo_sel;
		logic [3:0]  hi_sel;
		logic [31:0] konst;
		logic        hdr_end;
		logic        go;
	} ctrl_t;

	// Datapath status fed back to the sequencer
	typedef struct packed {
		logic frame_open;
		logic pix_pad;
	} stat_t;

	// One result item
	typedef struct packed {
		logic        valid;
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
		logic        eof;
	} emit_t;

endpackage

// ----- rtl/core/bmpw_sequencer.sv -----
module bmpw_sequencer
	import bmpw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	input  logic       s_func,
	input  logic [1:0] ver,
	input  logic       out_free,
	input  stat_t      stat,
	output ctrl_t      ctrl,
	output logic       s_ready
);

	localparam int PCW = 6;
	localparam logic [PCW-1:0] PC_WAIT   = 6'd0;
	localparam logic [PCW-1:0] PC_STRIDE = 6'd1;
	localparam logic [PCW-1:0] PC_ISIZE  = 6'd2;
	localparam logic [PCW-1:0] PC_FSIZE  = 6'd3;
	localparam logic [PCW-1:0] PC_HDR0   = 6'd4;
	localparam logic [PCW-1:0] PC_PIX    = 6'd39;
	localparam logic [PCW-1:0] PC_PAD    = 6'd40;
	localparam logic [PCW-1:0] PC_LAST   = 6'd40;

	localparam logic [2:0] C_NEXT    = 3'd0;
	localparam logic [2:0] C_GOTO    = 3'd1;
	localparam logic [2:0] C_HDR_END = 3'd2;
	localparam logic [2:0] C_NO_PAD  = 3'd3;
	localparam logic [2:0] C_ITEM    = 3'd4;

	typedef struct packed {
		logic [2:0]     op;
		logic [2:0]     cond;
		logic [PCW-1:0] target;
		logic [3:0]     lo_sel;
		logic [3:0]     hi_sel;
		logic [31:0]    konst;
		logic [3:0]     end_mask;
	} uword_t;

	// Control store: bookkeeping steps, then one step per 32-bit header word,
	// then the pixel and padding steps
	function automatic uword_t rom(input logic [PCW-1:0] step);
		uword_t uw;
		uw = '{op: OP_HDR, cond: C_NEXT, target: PC_WAIT, lo_sel: F_ZERO,
			hi_sel: F_ZERO, konst: 32'h0, end_mask: 4'b0000};
		case (step)
			PC_WAIT: begin
				uw.op = OP_WAIT; uw.cond = C_ITEM; uw.target = PC_PIX;
			end
			PC_STRIDE: uw.op = OP_STRIDE;
			PC_ISIZE:  uw.op = OP_ISIZE;
			PC_FSIZE:  uw.op = OP_FSIZE;
			PC_HDR0 + 6'd0: begin
				uw.konst = 32'h0000_4d42; uw.hi_sel = F_FS_LO;
			end
			PC_HDR0 + 6'd1: uw.lo_sel = F_FS_HI;
			PC_HDR0 + 6'd2: uw.hi_sel = F_OFF;
			PC_HDR0 + 6'd3: uw.hi_sel = F_DIB;
			PC_HDR0 + 6'd4: uw.hi_sel = F_W;
			PC_HDR0 + 6'd5: uw.hi_sel = F_H;
			PC_HDR0 + 6'd6: uw.konst = 32'h0001_0000;
			PC_HDR0 + 6'd7: begin
				uw.lo_sel = F_BPP; uw.hi_sel = F_COMP;
			end
			PC_HDR0 + 6'd8: uw.hi_sel = F_ISZ_LO;
			PC_HDR0 + 6'd9: uw.lo_sel = F_ISZ_HI;
			PC_HDR0 + 6'd13: begin
				uw.cond = C_HDR_END; uw.end_mask = 4'b0001;
			end
			PC_HDR0 + 6'd14: uw.konst = 32'hff00_00ff;
			PC_HDR0 + 6'd15: uw.konst = 32'h00ff_0000;
			PC_HDR0 + 6'd17: begin
				uw.konst = 32'h0000_ff00; uw.cond = C_HDR_END; uw.end_mask = 4'b0010;
			end
			PC_HDR0 + 6'd30: begin
				uw.konst = 32'h0004_0000; uw.cond = C_HDR_END; uw.end_mask = 4'b0100;
			end
			PC_HDR0 + 6'd34: begin
				uw.cond = C_HDR_END; uw.end_mask = 4'b1111;
			end
			PC_PIX: begin
				uw.op = OP_PIX; uw.cond = C_NO_PAD;
			end
			PC_PAD: begin
				uw.op = OP_PAD; uw.cond = C_GOTO;
			end
			default: ;
		endcase
		if (step > PC_LAST) begin
			uw.op = OP_NOP; uw.cond = C_GOTO; uw.target = PC_WAIT;
		end
		return uw;
	endfunction

	logic [PCW-1:0] pc_q;
	logic [PCW-1:0] pc_nx;
	uword_t         uw;
	logic           emits;
	logic           go;
	logic           hdr_end;

	assign uw      = rom(pc_q);
	assign hdr_end = uw.end_mask[ver];
	assign emits   = (uw.op == OP_HDR) || (uw.op == OP_PIX) || (uw.op == OP_PAD);
	assign go      = (uw.op == OP_WAIT) ? s_valid : (emits ? out_free : 1'b1);
	assign s_ready = (uw.op == OP_WAIT);

	assign ctrl = '{op: uw.op, lo_sel: uw.lo_sel, hi_sel: uw.hi_sel, konst: uw.konst,
		hdr_end: hdr_end, go: go};

	always_comb begin
		pc_nx = pc_q;
		if (go) begin
			unique case (uw.cond)
				C_NEXT:    pc_nx = pc_q + PCW'(1);
				C_GOTO:    pc_nx = uw.target;
				C_HDR_END: pc_nx = hdr_end ? uw.target : pc_q + PCW'(1);
				C_NO_PAD:  pc_nx = stat.pix_pad ? pc_q + PCW'(1) : uw.target;
				C_ITEM: begin
					if (!s_func) begin
						pc_nx = pc_q + PCW'(1);
					end else if (stat.frame_open) begin
						pc_nx = uw.target;
					end
				end
				default:   pc_nx = PC_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_nx;
		end
	end

endmodule

// ----- rtl/core/bmpw_datapath.sv -----
module bmpw_datapath
	import bmpw_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	input  logic [1:0]          ver,
	input  logic [CfgDataW-1:0] width_reg,
	input  logic [CfgDataW-1:0] height_reg,
	input  logic [31:0]         pix_in,
	output stat_t               stat,
	output emit_t               emit
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = WW + 2;

	function automatic logic [7:0] dib_bytes(input logic [1:0] v);
		logic [7:0] d;
		case (v)
			2'd0:    d = 8'd40;
			2'd1:    d = 8'd56;
			2'd2:    d = 8'd108;
			default: d = 8'd124;
		endcase
		return d;
	endfunction

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [15:0]   ew16;
	logic [15:0]   eh16;
	logic          is24;
	logic [7:0]    dib;
	logic [7:0]    off;
	logic [1:0]    pad;

	logic [12:0]   col_q;
	logic [12:0]   row_q;
	logic          open_q;
	logic          eof_q;
	logic [SW-1:0] stride_q;
	logic [31:0]   isz_q;
	logic [31:0]   fsize_q;
	logic [31:0]   pix_q;

	logic [SW-1:0] prod;
	logic [SW-1:0] psum;
	logic [12:0]   col_inc;
	logic [12:0]   row_inc;
	logic          row_end;
	logic          frame_end;
	logic          pix_pad;
	logic          fire;
	logic [31:0]   hdr_word;

	// Zero reads as one, anything above the maximum saturates
	always_comb begin
		if (width_reg == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_reg);
		end
		if (height_reg == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_reg);
		end
	end

	assign ew16 = 16'(eff_w);
	assign eh16 = 16'(eff_h);
	assign is24 = (ver == 2'd0);
	assign dib  = dib_bytes(ver);
	assign off  = dib + 8'd14;
	// 3 bytes per pixel leaves width mod 4 bytes of padding, 4 bytes none
	assign pad  = is24 ? ew16[1:0] : 2'd0;

	assign prod = is24 ? (SW'(eff_w) + (SW'(eff_w) << 1)) : (SW'(eff_w) << 2);
	assign psum = prod + SW'(3);

	assign col_inc   = col_q + 13'd1;
	assign row_inc   = row_q + 13'd1;
	assign row_end   = (col_inc == '0) || (16'(col_inc) >= ew16);
	assign frame_end = row_end && ((row_inc == '0) || (16'(row_inc) >= eh16));
	assign pix_pad   = row_end && (pad != 2'd0);

	assign stat = '{frame_open: open_q, pix_pad: pix_pad};
	assign fire = ctrl.go;

	function automatic logic [15:0] field(input logic [3:0] sel, input logic [31:0] fs,
		input logic [31:0] isz, input logic [7:0] o, input logic [7:0] d,
		input logic [15:0] w, input logic [15:0] h, input logic v24);
		logic [15:0] f;
		case (sel)
			F_FS_LO:  f = fs[15:0];
			F_FS_HI:  f = fs[31:16];
			F_OFF:    f = 16'(o);
			F_DIB:    f = 16'(d);
			F_W:      f = w;
			F_H:      f = h;
			F_BPP:    f = v24 ? 16'd24 : 16'd32;
			F_COMP:   f = v24 ? 16'd0 : 16'd3;
			F_ISZ_LO: f = isz[15:0];
			F_ISZ_HI: f = isz[31:16];
			default:  f = 16'd0;
		endcase
		return f;
	endfunction

	assign hdr_word = (ctrl.konst
		| {field(ctrl.hi_sel, fsize_q, isz_q, off, dib, ew16, eh16, is24),
		   field(ctrl.lo_sel, fsize_q, isz_q, off, dib, ew16, eh16, is24)})
		& (ctrl.hdr_end ? 32'h0000_ffff : 32'hffff_ffff);

	always_comb begin
		emit = '{valid: 1'b0, word: 32'h0, count: 3'd0, last: 1'b0, eof: 1'b0};
		unique case (ctrl.op)
			OP_HDR: begin
				emit.valid = fire;
				emit.word  = hdr_word;
				emit.count = ctrl.hdr_end ? 3'd2 : 3'd4;
				emit.last  = ctrl.hdr_end;
			end
			OP_PIX: begin
				emit.valid = fire;
				emit.word  = is24 ? {8'h00, pix_q[7:0], pix_q[15:8], pix_q[23:16]}
					: {pix_q[31:24], pix_q[7:0], pix_q[15:8], pix_q[23:16]};
				emit.count = is24 ? 3'd3 : 3'd4;
				emit.last  = !pix_pad;
				emit.eof   = frame_end && !pix_pad;
			end
			OP_PAD: begin
				emit.valid = fire;
				emit.count = {1'b0, pad};
				emit.last  = 1'b1;
				emit.eof   = eof_q;
			end
			default: ;
		endcase
	end

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			open_q <= 1'b0;
			eof_q  <= 1'b0;
		end else if (fire) begin
			if (ctrl.op == OP_STRIDE) begin
				col_q  <= '0;
				row_q  <= '0;
				open_q <= 1'b1;
			end else if (ctrl.op == OP_PIX) begin
				eof_q <= frame_end;
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? 13'd0 : row_inc;
					if (frame_end) begin
						open_q <= 1'b0;
					end
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

	// Geometry and pixel payload
	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.op)
				OP_WAIT:   pix_q    <= pix_in;
				OP_STRIDE: stride_q <= {psum[SW-1:2], 2'b00};
				OP_ISIZE:  isz_q    <= 32'(stride_q) * 32'(eh16);
				OP_FSIZE:  fsize_q  <= isz_q + 32'(off);
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/bmp_file_stream_writer_core.sv -----
// BMP file stream writer, microcoded.
// Start item: take, stride, isize, fsize steps, then one header word a cycle unless stalled:
//   14, 18, 31 or 35 words for header versions 0 to 3 (set by end marks in the control store).
// Pixel item: take, emit and, at a padded row end, pad steps; one output register.
// Output stalls hold the sequencer on its current emit step.
// Reset (arst_n low, asynchronous): no frame open, counters zero, version 0, width and height 1.
module bmp_file_stream_writer_core
	import bmpw_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	// Pixel / command stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
	input  logic                s_tuser,   // func: 0 start frame, 1 pixel
	// File byte stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // out_word[31:0], byte_count[34:32], zero[39:35]
	output logic                m_tlast,
	output logic                m_tuser,   // end_of_frame
	// Register writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [1:0]          ver_q;
	logic [CfgDataW-1:0] width_q;
	logic [CfgDataW-1:0] height_q;

	logic                m_valid_q;
	logic [31:0]         m_word_q;
	logic [2:0]          m_count_q;
	logic                m_last_q;
	logic                m_eof_q;

	ctrl_t               ctrl;
	stat_t               stat;
	emit_t               emit;
	logic                out_free;

	// Registers are always writable; user writes must come only while the block is idle, unchecked
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q    <= 2'd0;
			width_q  <= CfgDataW'(1);
			height_q <= CfgDataW'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER_VERSION: ver_q    <= cfg_data[1:0];
				REG_IMAGE_WIDTH:    width_q  <= cfg_data;
				REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The output register is free when empty or being drained this cycle
	assign out_free = !m_valid_q || m_tready;

	bmpw_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_func   (s_tuser),
		.ver      (ver_q),
		.out_free (out_free),
		.stat     (stat),
		.ctrl     (ctrl),
		.s_ready  (s_tready)
	);

	bmpw_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.ver        (ver_q),
		.width_reg  (width_q),
		.height_reg (height_q),
		.pix_in     (s_tdata),
		.stat       (stat),
		.emit       (emit)
	);

	// Output item register: load on an emit step, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_word_q  <= emit.word;
			m_count_q <= emit.count;
			m_last_q  <= emit.last;
			m_eof_q   <= emit.eof;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, m_count_q, m_word_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_eof_q;

endmodule
